FILE: sv/rwcw_pkg.sv
`default_nettype none
package rwcw_pkg;

  localparam int unsigned PosWidth = 33;
  localparam logic [PosWidth-1:0] PosMax = {PosWidth{1'b1}};
  localparam logic [PosWidth-1:0] RiffPreamble = 33'd8;
  localparam logic [PosWidth-1:0] ChunkHeaderLen = 33'd8;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_CHDR,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOT_WEBP = 3'd1,
    ST_TRUNC    = 3'd2,
    ST_FRAMING  = 3'd3,
    ST_RUNAWAY  = 3'd4
  } status_t;

  typedef enum logic {
    KIND_CHUNK  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       record_kind;
    logic [31:0] chunk_tag;
    logic [31:0] chunk_length;
    status_t     status;
    logic        last;
  } record_t;

  function automatic logic [7:0] riff_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h52;
      2'd1:    b = 8'h49;
      2'd2:    b = 8'h46;
      default: b = 8'h46;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] webp_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h57;
      2'd1:    b = 8'h45;
      2'd2:    b = 8'h42;
      default: b = 8'h50;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: sv/rwcw_byte_if.sv
`default_nettype none
interface rwcw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface
`default_nettype wire

FILE: sv/rwcw_rec_if.sv
`default_nettype none
interface rwcw_rec_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [31:0] chunk_tag;
  logic [31:0] chunk_length;
  logic [2:0]  status;
  logic        last;

  modport source (
    output valid, output record_kind, output chunk_tag, output chunk_length,
    output status, output last, input ready
  );
  modport sink (
    input valid, input record_kind, input chunk_tag, input chunk_length,
    input status, input last, output ready
  );
endinterface
`default_nettype wire

FILE: sv/riff_webp_chunk_walker_unit.sv
`default_nettype none
// Walks a RIFF/WebP file given one byte per word on the byte channel and
// emits a record word for each well-formed chunk header, then one status
// word (last set) on the byte flagged end_of_file, after which it is ready
// for the next file. The block takes one byte per cycle; a byte that
// completes a chunk header and also ends the file yields two record words,
// which a four-entry output queue absorbs, so the byte channel stalls only
// while that queue holds more than two words.
module riff_webp_chunk_walker_unit (
  input  logic             clk,
  input  logic             rst,
  rwcw_byte_if.sink        bytes,
  rwcw_rec_if.source       records
);
  import rwcw_pkg::*;

  phase_t               phase, phase_next;
  logic [PosWidth-1:0]  file_position, file_position_next;
  logic [PosWidth-1:0]  declared_end, declared_end_next;
  logic [3:0]           header_byte_count, header_byte_count_next;
  logic [31:0]          tag_shift, tag_shift_next;
  logic [31:0]          size_shift, size_shift_next;
  logic [PosWidth-1:0]  payload_left, payload_left_next;
  status_t              verdict, verdict_next;

  logic                 accept;
  logic [7:0]           b;
  logic [PosWidth-1:0]  pos_inc;
  logic [PosWidth-1:0]  dend_sel;
  logic                 bc_done;
  logic                 bc_framing;
  logic [31:0]          size_full;
  logic [PosWidth-1:0]  adv;
  logic                 runaway;
  logic [PosWidth-1:0]  pl_dec;
  logic [31:0]          byte_shifted;
  logic [2:0]           chdr_idx;
  logic                 do_begin;
  logic                 push_chunk;
  logic                 push_status;
  status_t              final_status;

  record_t                  queue [QueueDepth];
  logic [QueuePtrWidth-1:0] wr_ptr, rd_ptr;
  logic [QueuePtrWidth:0]   count;
  logic [1:0]               n_push;
  logic                     pop;
  record_t                  rec_a, rec_b, head;

  assign accept = bytes.valid && bytes.ready;
  assign b = bytes.data_byte;
  assign pos_inc = (file_position == PosMax) ? file_position : file_position + 33'd1;
  assign dend_sel = (phase == PH_HEADER) ? ({1'b0, size_shift} + RiffPreamble) : declared_end;
  assign bc_done = pos_inc >= dend_sel;
  assign bc_framing = (dend_sel - pos_inc) < ChunkHeaderLen;
  assign size_full = {b, size_shift[23:0]};
  assign adv = ({1'b0, size_full} + 33'd1) & ~33'd1;
  assign runaway = ({1'b0, pos_inc} + {1'b0, adv}) > {1'b0, declared_end};
  assign pl_dec = (payload_left != '0) ? payload_left - 33'd1 : payload_left;
  assign byte_shifted = {24'b0, b} << {header_byte_count[1:0], 3'b000};
  assign chdr_idx = header_byte_count[2:0];

  always_comb begin
    phase_next = phase;
    file_position_next = file_position;
    declared_end_next = declared_end;
    header_byte_count_next = header_byte_count;
    tag_shift_next = tag_shift;
    size_shift_next = size_shift;
    payload_left_next = payload_left;
    verdict_next = verdict;
    do_begin = 1'b0;
    push_chunk = 1'b0;
    push_status = 1'b0;
    final_status = ST_OK;
    if (accept) begin
      file_position_next = pos_inc;
      unique case (phase)
        PH_HEADER: begin
          header_byte_count_next = header_byte_count + 4'd1;
          if (header_byte_count < 4'd4) begin
            if (b != riff_byte(header_byte_count[1:0])) begin
              verdict_next = ST_NOT_WEBP;
              phase_next = PH_DONE;
            end
          end else if (header_byte_count < 4'd8) begin
            size_shift_next = size_shift | byte_shifted;
          end else if (header_byte_count < 4'd12) begin
            if (b != webp_byte(header_byte_count[1:0])) begin
              verdict_next = ST_NOT_WEBP;
              phase_next = PH_DONE;
            end else if (header_byte_count == 4'd11) begin
              declared_end_next = dend_sel;
              do_begin = 1'b1;
            end
          end
        end
        PH_CHDR: begin
          header_byte_count_next = {1'b0, chdr_idx} + 4'd1;
          if (!chdr_idx[2]) begin
            tag_shift_next = tag_shift | byte_shifted;
          end else begin
            size_shift_next = size_shift | byte_shifted;
          end
          if (chdr_idx == 3'd7) begin
            if (runaway) begin
              verdict_next = ST_RUNAWAY;
              phase_next = PH_DONE;
            end else begin
              push_chunk = 1'b1;
              if (adv == '0) begin
                do_begin = 1'b1;
              end else begin
                payload_left_next = adv;
                phase_next = PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          payload_left_next = pl_dec;
          if (pl_dec == '0) begin
            do_begin = 1'b1;
          end
        end
        PH_DONE: begin
        end
      endcase
      if (do_begin) begin
        if (bc_done) begin
          phase_next = PH_DONE;
        end else if (bc_framing) begin
          verdict_next = ST_FRAMING;
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_CHDR;
          header_byte_count_next = '0;
          tag_shift_next = '0;
          size_shift_next = '0;
        end
      end
      if (bytes.end_of_file) begin
        push_status = 1'b1;
        if (phase_next == PH_HEADER) begin
          final_status = ST_NOT_WEBP;
        end else if (verdict_next != ST_NOT_WEBP && pos_inc < declared_end_next) begin
          final_status = ST_TRUNC;
        end else begin
          final_status = verdict_next;
        end
        phase_next = PH_HEADER;
        file_position_next = '0;
        declared_end_next = '0;
        header_byte_count_next = '0;
        tag_shift_next = '0;
        size_shift_next = '0;
        payload_left_next = '0;
        verdict_next = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      file_position <= '0;
      declared_end <= '0;
      header_byte_count <= '0;
      tag_shift <= '0;
      size_shift <= '0;
      payload_left <= '0;
      verdict <= ST_OK;
    end else begin
      phase <= phase_next;
      file_position <= file_position_next;
      declared_end <= declared_end_next;
      header_byte_count <= header_byte_count_next;
      tag_shift <= tag_shift_next;
      size_shift <= size_shift_next;
      payload_left <= payload_left_next;
      verdict <= verdict_next;
    end
  end

  always_comb begin
    rec_b.record_kind = KIND_STATUS;
    rec_b.chunk_tag = '0;
    rec_b.chunk_length = '0;
    rec_b.status = final_status;
    rec_b.last = 1'b1;
    if (push_chunk) begin
      rec_a.record_kind = KIND_CHUNK;
      rec_a.chunk_tag = tag_shift;
      rec_a.chunk_length = size_full;
      rec_a.status = ST_OK;
      rec_a.last = 1'b0;
    end else begin
      rec_a = rec_b;
    end
  end

  assign n_push = {1'b0, push_chunk} + {1'b0, push_status};
  assign pop = records.valid && records.ready;
  assign bytes.ready = count <= 3'(QueueDepth - 2);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      queue[wr_ptr] <= rec_a;
    end
    if (n_push == 2'd2) begin
      queue[wr_ptr + QueuePtrWidth'(1)] <= rec_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + QueuePtrWidth'(n_push);
      rd_ptr <= rd_ptr + QueuePtrWidth'(pop);
      count <= count + (QueuePtrWidth + 1)'(n_push) - (QueuePtrWidth + 1)'(pop);
    end
  end

  assign head = queue[rd_ptr];
  assign records.valid = count != '0;
  assign records.record_kind = head.record_kind;
  assign records.chunk_tag = head.chunk_tag;
  assign records.chunk_length = head.chunk_length;
  assign records.status = head.status;
  assign records.last = head.last;

endmodule
`default_nettype wire

FILE: dv/riff_webp_chunk_walker_unit_tb.sv
`timescale 1ns / 100ps
module riff_webp_chunk_walker_unit_tb;
  import rwcw_pkg::*;

  localparam logic [31:0] RiffTag = 32'h46464952;
  localparam logic [31:0] WebpTag = 32'h50424557;
  localparam int unsigned MaxRowBytes = 32;
  localparam int unsigned NumDirected = 16;
  localparam int unsigned RandomBytes = 540;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 16;

  typedef struct {
    logic [8*MaxRowBytes-1:0] text;
    int unsigned len;
    logic pinned;
    status_t verdict;
  } file_row_t;

  file_row_t directed_files [NumDirected] = '{
    '{{"RIF"}, 3, 1'b1, ST_NOT_WEBP},
    '{{8'h00}, 1, 1'b1, ST_NOT_WEBP},
    '{{"RIFX", 32'h04000000, "WEBP"}, 12, 1'b1, ST_NOT_WEBP},
    '{{"RIFF", 32'h04000000, "WEBQ"}, 12, 1'b1, ST_NOT_WEBP},
    '{{"RIFF", 32'h04000000, "WEBP"}, 12, 1'b1, ST_OK},
    '{{"RIFF", 32'h00000000, "WEBP"}, 12, 1'b1, ST_OK},
    '{{"RIFF", 32'h0E000000, "WEBP", "VP8 ", 32'h01000000, 16'hAB00}, 22, 1'b0, ST_OK},
    '{{"RIFF", 32'h0E000000, "WEBP", "VP8 ", 32'h01000000, 8'hAB}, 21, 1'b1, ST_TRUNC},
    '{{"RIFF", 32'h08000000, "WEBP", 32'h00000000}, 16, 1'b1, ST_FRAMING},
    '{{"RIFF", 32'h0C000000, "WEBP", "ALPH", 32'h02000000}, 20, 1'b1, ST_RUNAWAY},
    '{{"RIFF", 32'h0C000000, "WEBP", "ALPH", 32'hFFFFFFFF}, 20, 1'b1, ST_RUNAWAY},
    '{{"RIFF", 32'h14000000, "WEBP", "EXIF", 32'h00000000, "ICCP", 32'h00000000}, 28,
      1'b0, ST_OK},
    '{{"RIFF", 32'h0E000000, "WEBP", "VP8 ", 32'h01000000, 16'hAB00, 16'hFFFF}, 24,
      1'b0, ST_OK},
    '{{"RIFF", 32'h16000000, "WEBP", "ALPH", 32'h64000000}, 20, 1'b1, ST_TRUNC},
    '{{"RIFF", 32'h0C000000, "WEBP", "VP8L", 32'h00000000}, 20, 1'b1, ST_OK},
    '{{"RIFF", 32'hFFFFFFFF, "WEBP"}, 12, 1'b1, ST_TRUNC}
  };

  logic clk;
  logic rst;

  rwcw_byte_if byte_ch ();
  rwcw_rec_if rec_ch ();

  riff_webp_chunk_walker_unit u_top (
    .clk(clk),
    .rst(rst),
    .bytes(byte_ch),
    .records(rec_ch)
  );

  phase_t walk_phase;
  logic [32:0] file_pos;
  logic [32:0] decl_end;
  logic [32:0] pad_left;
  logic [3:0] hdr_idx;
  logic [31:0] tag_acc;
  logic [31:0] len_acc;
  status_t file_verdict;

  record_t records_due[$];
  logic [7:0] file_bytes[$];

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  logic hold_off_req = 1'b0;
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned files_walked = 0;
  int unsigned chunk_words = 0;
  int unsigned verdict_seen [5] = '{0, 0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic walker_reset();
    walk_phase = PH_HEADER;
    file_pos = '0;
    decl_end = '0;
    pad_left = '0;
    hdr_idx = '0;
    tag_acc = '0;
    len_acc = '0;
    file_verdict = ST_OK;
  endtask

  task automatic open_chunk();
    if (file_pos >= decl_end) begin
      walk_phase = PH_DONE;
    end else if (decl_end - file_pos < ChunkHeaderLen) begin
      file_verdict = ST_FRAMING;
      walk_phase = PH_DONE;
    end else begin
      walk_phase = PH_CHDR;
      hdr_idx = '0;
      tag_acc = '0;
      len_acc = '0;
    end
  endtask

  task automatic walk_byte(input logic [7:0] b, input logic eof, input logic pin,
                           input status_t pinned_st);
    int idx;
    logic [32:0] padded;
    logic [33:0] reach;
    status_t final_st;
    if (file_pos != PosMax) file_pos = file_pos + 33'd1;
    case (walk_phase)
      PH_HEADER: begin
        idx = int'(hdr_idx);
        if (idx < 4) begin
          if (b != RiffTag[8*idx +: 8]) begin
            file_verdict = ST_NOT_WEBP;
            walk_phase = PH_DONE;
          end
        end else if (idx < 8) begin
          len_acc[8*(idx-4) +: 8] = b;
        end else if (idx < 12) begin
          if (b != WebpTag[8*(idx-8) +: 8]) begin
            file_verdict = ST_NOT_WEBP;
            walk_phase = PH_DONE;
          end
        end
        hdr_idx = hdr_idx + 4'd1;
        if (walk_phase == PH_HEADER && idx == 11) begin
          decl_end = RiffPreamble + {1'b0, len_acc};
          open_chunk();
        end
      end
      PH_CHDR: begin
        idx = int'(hdr_idx[2:0]);
        if (idx < 4) tag_acc[8*idx +: 8] = b;
        else len_acc[8*(idx-4) +: 8] = b;
        hdr_idx = 4'(idx + 1);
        if (idx == 7) begin
          padded = ({1'b0, len_acc} + 33'd1) & ~33'd1;
          reach = {1'b0, file_pos} + {1'b0, padded};
          if (reach > {1'b0, decl_end}) begin
            file_verdict = ST_RUNAWAY;
            walk_phase = PH_DONE;
          end else begin
            records_due.push_back('{record_kind: KIND_CHUNK, chunk_tag: tag_acc,
                                    chunk_length: len_acc, status: ST_OK, last: 1'b0});
            if (padded == '0) begin
              open_chunk();
            end else begin
              pad_left = padded;
              walk_phase = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        if (pad_left != '0) pad_left = pad_left - 33'd1;
        if (pad_left == '0) open_chunk();
      end
      default: begin
      end
    endcase
    if (eof) begin
      final_st = file_verdict;
      if (walk_phase == PH_HEADER) final_st = ST_NOT_WEBP;
      else if (final_st != ST_NOT_WEBP && file_pos < decl_end) final_st = ST_TRUNC;
      if (pin) final_st = pinned_st;
      records_due.push_back('{record_kind: KIND_STATUS, chunk_tag: 32'd0,
                              chunk_length: 32'd0, status: final_st, last: 1'b1});
      walker_reset();
    end
  endtask

  always @(posedge clk) begin
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      walk_byte(byte_ch.data_byte, byte_ch.end_of_file,
                files_walked < NumDirected && directed_files[files_walked % NumDirected].pinned,
                directed_files[files_walked % NumDirected].verdict);
      if (byte_ch.end_of_file) files_walked++;
    end
  end

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_records
    record_t want;
    if (!rst && rec_ch.valid && rec_ch.ready) begin
      if (records_due.size() == 0) begin
        $error("record word arrived with nothing outstanding");
        mismatches++;
      end else begin
        want = records_due.pop_front();
        compare_field("record_kind", 32'(want.record_kind), 32'(rec_ch.record_kind));
        compare_field("chunk_tag", want.chunk_tag, rec_ch.chunk_tag);
        compare_field("chunk_length", want.chunk_length, rec_ch.chunk_length);
        compare_field("status", 32'(want.status), 32'(rec_ch.status));
        compare_field("last", 32'(want.last), 32'(rec_ch.last));
      end
      if (rec_ch.record_kind == KIND_CHUNK) chunk_words++;
      else if (rec_ch.status < 3'd5) verdict_seen[rec_ch.status]++;
    end
  end

  initial begin
    rec_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rec_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      rec_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((byte_ch.valid && byte_ch.ready) || (rec_ch.valid && rec_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.end_of_file <= eof;
    do @(posedge clk); while (!byte_ch.ready);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) begin
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    end
    bytes_sent += file_bytes.size();
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
  endtask

  // Mostly well-formed files; the rest have a wrong size, a cut tail,
  // trailing bytes, a damaged magic or are plain noise.
  task automatic build_random_file();
    logic [31:0] ck_len;
    logic [31:0] decl;
    int unsigned n_chunks;
    int unsigned mode;
    int unsigned spot;
    file_bytes = {};
    push_word(RiffTag);
    push_word(32'd0);
    push_word(WebpTag);
    n_chunks = $urandom_range(0, 3);
    for (int k = 0; k < n_chunks; k++) begin
      ck_len = ($urandom_range(15) == 0) ? $urandom : 32'($urandom_range(0, 9));
      push_word($urandom);
      push_word(ck_len);
      if (ck_len > 32'd9) break;
      repeat ((ck_len + 32'd1) & ~32'd1) file_bytes.push_back(8'($urandom));
    end
    decl = 32'(file_bytes.size() - 8);
    mode = $urandom_range(99);
    if (mode < 12 && decl >= 32'd7) decl = decl + 32'($urandom_range(0, 14)) - 32'd7;
    else if (mode >= 12 && mode < 16) decl = $urandom;
    for (int i = 0; i < 4; i++) file_bytes[4 + i] = decl[8*i +: 8];
    if (mode >= 16 && mode < 26) begin
      repeat ($urandom_range(1, file_bytes.size() - 1)) void'(file_bytes.pop_back());
    end else if (mode >= 26 && mode < 34) begin
      repeat ($urandom_range(1, 6)) file_bytes.push_back(8'($urandom));
    end else if (mode >= 34 && mode < 42) begin
      spot = $urandom_range(0, 7);
      if (spot >= 4) spot += 4;
      file_bytes[spot] = file_bytes[spot] ^ (8'd1 << $urandom_range(0, 7));
    end else if (mode >= 42 && mode < 46) begin
      file_bytes = {};
      repeat ($urandom_range(1, 20)) file_bytes.push_back(8'($urandom));
    end
  endtask

  initial begin : stimulus
    int unsigned rand_start;
    rst <= 1'b1;
    byte_ch.valid <= 1'b0;
    byte_ch.data_byte <= 8'd0;
    byte_ch.end_of_file <= 1'b0;
    src_idle_pct = 38;
    snk_idle_pct = 45;
    walker_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NumDirected; r++) begin
      file_bytes = {};
      for (int i = int'(directed_files[r].len) - 1; i >= 0; i--) begin
        file_bytes.push_back(directed_files[r].text[8*i +: 8]);
      end
      send_file();
    end

    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RandomBytes) begin
      if (bytes_sent - rand_start >= 2 * RandomBytes / 3) begin
        // The sender stops idling here, so a long receiver stall fills the block.
        if (src_idle_pct != 0) hold_off_req = 1'b1;
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else if (bytes_sent - rand_start >= RandomBytes / 3) begin
        src_idle_pct = 45;
        snk_idle_pct = 38;
      end
      build_random_file();
      send_file();
    end
    byte_ch.valid <= 1'b0;

    while (records_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Walked %0d files in %0d bytes; %0d chunk records checked.",
             files_walked, bytes_sent, chunk_words);
    $display("Verdicts: ok %0d, not webp %0d, truncated %0d, framing %0d, runaway %0d.",
             verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3],
             verdict_seen[4]);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: riff_webp_chunk_walker_unit.f
sv/rwcw_pkg.sv
sv/rwcw_byte_if.sv
sv/rwcw_rec_if.sv
sv/riff_webp_chunk_walker_unit.sv
dv/riff_webp_chunk_walker_unit_tb.sv
